/* rtl/core/lores_layer_pixel_pipeline_top_macros.svh */
// Assertion macros for the low-resolution layer pixel pipeline.
// Each macro takes a label, a clock, an active-low reset, a condition and a
// consequence; the synthesis build sees empty bodies.
`ifndef LORES_LAYER_PIXEL_PIPELINE_TOP_MACROS_SVH
`define LORES_LAYER_PIXEL_PIPELINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Consequence holds in the same cycle as the condition.
`define LORES_ASSERT_NOW(lbl, aclk, arstn, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!arstn) (ante) |-> (cons)) \
        else $error("lores pipeline check failed");
// Consequence holds starting in the cycle after the condition.
`define LORES_ASSERT_NEXT(lbl, aclk, arstn, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!arstn) (ante) |=> (cons)) \
        else $error("lores pipeline check failed");
`else
`define LORES_ASSERT_NOW(lbl, aclk, arstn, ante, cons)
`define LORES_ASSERT_NEXT(lbl, aclk, arstn, ante, cons)
`endif

`endif

/* rtl/core/lores_pkg.sv */
// ----------------------------------------------------------------------------
// lores_pkg
// Types and constants shared by the low-resolution layer pixel pipeline.
// ----------------------------------------------------------------------------
package lores_pkg;

    localparam int unsigned ADDR_W         = 5;
    localparam int unsigned SCREEN_LINES   = 192;
    localparam int unsigned HALF_SPLIT_ROW = 48;
    localparam logic [13:0] HALF_OFFSET    = 14'h2000;
    localparam logic [3:0]  ULAP_BITS      = 4'b1100;
    localparam logic [31:0] CLIP_RESET     = 32'hFF00FF00;
    localparam logic [7:0]  TRANSP_RESET   = 8'hE3;

    typedef enum logic [2:0] {
        REG_CLIP     = 3'd0,
        REG_SCROLL   = 3'd1,
        REG_MODE     = 3'd2,
        REG_TRANSP   = 3'd3,
        REG_PAL_BASE = 3'd4,
        REG_PAL_ALT  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] clip_window;
        logic [15:0] scroll_offsets;
        logic [7:0]  mode_flags;
        logic [7:0]  transparent_colour;
        logic [9:0]  palette_base;
        logic [9:0]  palette_alt_base;
    } cfg_t;

    typedef struct packed {
        logic [8:0] hpos;
        logic [7:0] vpos;
        logic [7:0] vram_byte;
        logic [8:0] pen_rgb;
    } req_t;

    typedef struct packed {
        logic [13:0] vram_addr;
        logic [10:0] pen_index;
        logic        draw_pixel;
    } rsp_t;

    // Payload handed from the scroll stages to the pen stage.
    typedef struct packed {
        logic [6:0] y;
        logic [7:0] vram_byte;
        logic       draw;
    } stage_t;

endpackage

/* rtl/core/lores_regs.sv */
// ----------------------------------------------------------------------------
// lores_regs
// APB register file holding clip, scroll, mode, transparency and palette settings.
// ----------------------------------------------------------------------------
module lores_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lores_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output lores_pkg::cfg_t              cfg
);
    import lores_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_CLIP:     cfg_next.clip_window        = pwdata;
                REG_SCROLL:   cfg_next.scroll_offsets     = pwdata[15:0];
                REG_MODE:     cfg_next.mode_flags         = pwdata[7:0];
                REG_TRANSP:   cfg_next.transparent_colour = pwdata[7:0];
                REG_PAL_BASE: cfg_next.palette_base       = pwdata[9:0];
                REG_PAL_ALT:  cfg_next.palette_alt_base   = pwdata[9:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CLIP:     prdata = cfg_reg.clip_window;
            REG_SCROLL:   prdata = {16'd0, cfg_reg.scroll_offsets};
            REG_MODE:     prdata = {24'd0, cfg_reg.mode_flags};
            REG_TRANSP:   prdata = {24'd0, cfg_reg.transparent_colour};
            REG_PAL_BASE: prdata = {22'd0, cfg_reg.palette_base};
            REG_PAL_ALT:  prdata = {22'd0, cfg_reg.palette_alt_base};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_window        <= CLIP_RESET;
            cfg_reg.scroll_offsets     <= 16'd0;
            cfg_reg.mode_flags         <= 8'd0;
            cfg_reg.transparent_colour <= TRANSP_RESET;
            cfg_reg.palette_base       <= 10'd0;
            cfg_reg.palette_alt_base   <= 10'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/lores_scroll.sv */
// ----------------------------------------------------------------------------
// lores_scroll
// Two stages: scroll sums with clip and transparency test, then line wrap.
// ----------------------------------------------------------------------------
module lores_scroll #(
    parameter int unsigned LINE_UNITS = 512,
    parameter int unsigned XW         = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lores_pkg::req_t   req,
    input  lores_pkg::cfg_t   cfg,
    output logic              out_valid,
    output logic [XW-1:0]     x,
    output lores_pkg::stage_t st
);
    import lores_pkg::*;

    localparam logic [11:0] LU1 = 12'(LINE_UNITS);
    localparam logic [11:0] LU2 = 12'(2 * LINE_UNITS);
    localparam logic [11:0] LU3 = 12'(3 * LINE_UNITS);
    localparam logic [8:0]  SL1 = 9'(SCREEN_LINES);
    localparam logic [8:0]  SL2 = 9'(2 * SCREEN_LINES);

    // stage 1
    logic        s1_valid_reg;
    logic [10:0] s1_sumx_reg;
    logic [8:0]  s1_sumy_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_draw_reg;
    logic [10:0] sumx_next;
    logic [8:0]  sumy_next;
    logic        draw_next;
    logic        in_clip;
    logic        opaque;

    // stage 2
    logic          s2_valid_reg;
    logic [XW-1:0] s2_x_reg;
    stage_t        s2_st_reg;
    logic [11:0]   sumx_w;
    logic [11:0]   xwrap;
    logic [8:0]    ywrap;
    stage_t        st_next;

    always_comb
    begin
        sumx_next = {2'b00, req.hpos} + {2'b00, cfg.scroll_offsets[7:0], 1'b0};
        sumy_next = {1'b0, req.vpos} + {1'b0, cfg.scroll_offsets[15:8]};
        in_clip = (req.hpos >= {cfg.clip_window[7:0], 1'b0})
               && (req.hpos <= {cfg.clip_window[15:8], 1'b1})
               && (req.vpos >= cfg.clip_window[23:16])
               && (req.vpos <= cfg.clip_window[31:24]);
        opaque = req.pen_rgb[8:1] != cfg.transparent_colour;
        draw_next = in_clip && opaque;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_sumx_reg <= sumx_next;
            s1_sumy_reg <= sumy_next;
            s1_byte_reg <= req.vram_byte;
            s1_draw_reg <= draw_next;
        end
    end

    // Wrap x by subtracting the largest fitting multiple of the line length, y by the screen lines.
    always_comb
    begin
        sumx_w = {1'b0, s1_sumx_reg};
        if (sumx_w >= LU3)
        begin
            xwrap = sumx_w - LU3;
        end
        else if (sumx_w >= LU2)
        begin
            xwrap = sumx_w - LU2;
        end
        else if (sumx_w >= LU1)
        begin
            xwrap = sumx_w - LU1;
        end
        else
        begin
            xwrap = sumx_w;
        end

        if (s1_sumy_reg >= SL2)
        begin
            ywrap = s1_sumy_reg - SL2;
        end
        else if (s1_sumy_reg >= SL1)
        begin
            ywrap = s1_sumy_reg - SL1;
        end
        else
        begin
            ywrap = s1_sumy_reg;
        end

        st_next.y         = ywrap[7:1];
        st_next.vram_byte = s1_byte_reg;
        st_next.draw      = s1_draw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_x_reg  <= xwrap[XW-1:0];
            s2_st_reg <= st_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign x         = s2_x_reg;
    assign st        = s2_st_reg;

endmodule

/* rtl/core/lores_pen.sv */
// ----------------------------------------------------------------------------
// lores_pen
// Output stage: video memory address, palette index and draw flag.
// ----------------------------------------------------------------------------
module lores_pen #(
    parameter int unsigned XW = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [XW-1:0]     x,
    input  lores_pkg::stage_t st,
    input  lores_pkg::cfg_t   cfg,
    output logic              out_valid,
    output lores_pkg::rsp_t   rsp
);
    import lores_pkg::*;

    localparam logic [6:0] SPLIT_ROW = 7'(HALF_SPLIT_ROW);

    logic          valid_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;
    logic [XW-1:0] x_q4;
    logic [XW-1:0] x_q8;
    logic [6:0]    y_half;
    logic          bottom;
    logic [14:0]   addr;
    logic [7:0]    attr;
    logic [9:0]    base;
    logic [3:0]    pal_hi;
    logic          four_bpp;

    always_comb
    begin
        four_bpp = cfg.mode_flags[0];
        x_q4     = x >> 2;
        x_q8     = x >> 3;
        bottom   = st.y >= SPLIT_ROW;
        y_half   = bottom ? (st.y - SPLIT_ROW) : st.y;

        if (four_bpp)
        begin
            addr = 15'(x_q8) + {2'b00, st.y, 6'd0}
                 + (cfg.mode_flags[1] ? {1'b0, HALF_OFFSET} : 15'd0);
            attr = x[2] ? {4'd0, st.vram_byte[3:0]} : {4'd0, st.vram_byte[7:4]};
        end
        else
        begin
            addr = 15'(x_q4) + {1'b0, y_half, 7'd0}
                 + (bottom ? {1'b0, HALF_OFFSET} : 15'd0);
            attr = st.vram_byte;
        end

        // ula plus forces the top two bits of the palette offset nibble
        pal_hi = (cfg.mode_flags[2] ? ULAP_BITS : 4'd0) | cfg.mode_flags[7:4];
        base   = cfg.mode_flags[3] ? cfg.palette_alt_base : cfg.palette_base;
        if (four_bpp)
        begin
            base = base | {2'b00, pal_hi, 4'd0};
        end

        rsp_next.vram_addr  = addr[13:0];
        rsp_next.pen_index  = {1'b0, base} + {3'd0, attr};
        rsp_next.draw_pixel = st.draw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/lores_layer_pixel_pipeline_top.sv */
// ----------------------------------------------------------------------------
// lores_layer_pixel_pipeline_top: low-resolution layer pixel pipeline
// Each start passes the scroll-sum, line-wrap and pen registers to done; one request per cycle, busy stays low.
// Three register stages: scroll sums, line wrap, address and pen formation.
// Async active-low reset clears valid bits and loads register reset values.
// ----------------------------------------------------------------------------
`include "lores_layer_pixel_pipeline_top_macros.svh"

module lores_layer_pixel_pipeline_top #(
    parameter int unsigned LINE_UNITS = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lores_pkg::req_t              req,
    output logic                         done,
    output lores_pkg::rsp_t              rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lores_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lores_pkg::*;

    localparam int unsigned XW = $clog2(LINE_UNITS);

    cfg_t          cfg;
    logic          accept;
    logic          s2_valid;
    logic [XW-1:0] s2_x;
    stage_t        s2_st;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    lores_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    lores_scroll #(
        .LINE_UNITS (LINE_UNITS),
        .XW         (XW)
    ) u_scroll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .req       (req),
        .cfg       (cfg),
        .out_valid (s2_valid),
        .x         (s2_x),
        .st        (s2_st)
    );

    lores_pen #(
        .XW (XW)
    ) u_pen (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .x         (s2_x),
        .st        (s2_st),
        .cfg       (cfg),
        .out_valid (done),
        .rsp       (rsp)
    );

    `LORES_ASSERT_NOW(a_done_has_request, clk, rst_n, done, $past(start, 3))
    `LORES_ASSERT_NEXT(a_request_gives_done, clk, rst_n, accept, ##2 done)
    `LORES_ASSERT_NOW(a_x_wrapped, clk, rst_n, s2_valid, 32'(s2_x) < LINE_UNITS)
    `LORES_ASSERT_NOW(a_y_in_picture, clk, rst_n, s2_valid, s2_st.y < 7'd96)

endmodule
